// ===== design/sscp_pkg.sv =====
package sscp_pkg;

    // Default coordinate width and parameter fraction width
    localparam int COORD_WIDTH_DEF = 32;
    localparam int PARAM_FRAC_DEF  = 16;

    // Fixed field widths
    localparam int THR_W  = 32;
    localparam int DIST_W = 64;

endpackage

// ===== design/sscp_if.sv =====
interface sscp_in_if #(
    parameter int COORD_WIDTH = sscp_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg1_start_x;
    logic signed [COORD_WIDTH-1:0] seg1_start_y;
    logic signed [COORD_WIDTH-1:0] seg1_start_z;
    logic signed [COORD_WIDTH-1:0] seg1_end_x;
    logic signed [COORD_WIDTH-1:0] seg1_end_y;
    logic signed [COORD_WIDTH-1:0] seg1_end_z;
    logic signed [COORD_WIDTH-1:0] seg2_start_x;
    logic signed [COORD_WIDTH-1:0] seg2_start_y;
    logic signed [COORD_WIDTH-1:0] seg2_start_z;
    logic signed [COORD_WIDTH-1:0] seg2_end_x;
    logic signed [COORD_WIDTH-1:0] seg2_end_y;
    logic signed [COORD_WIDTH-1:0] seg2_end_z;

    modport source (
        output valid, seg1_start_x, seg1_start_y, seg1_start_z,
               seg1_end_x, seg1_end_y, seg1_end_z,
               seg2_start_x, seg2_start_y, seg2_start_z,
               seg2_end_x, seg2_end_y, seg2_end_z,
        input  ready
    );
    modport sink (
        input  valid, seg1_start_x, seg1_start_y, seg1_start_z,
               seg1_end_x, seg1_end_y, seg1_end_z,
               seg2_start_x, seg2_start_y, seg2_start_z,
               seg2_end_x, seg2_end_y, seg2_end_z,
        output ready
    );
endinterface

interface sscp_out_if #(
    parameter int COORD_WIDTH     = sscp_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = sscp_pkg::PARAM_FRAC_DEF
);
    logic                              valid;
    logic                              ready;
    logic        [PARAM_FRAC_BITS:0]   param_s;
    logic        [PARAM_FRAC_BITS:0]   param_t;
    logic signed [COORD_WIDTH-1:0]     near1_x;
    logic signed [COORD_WIDTH-1:0]     near1_y;
    logic signed [COORD_WIDTH-1:0]     near1_z;
    logic signed [COORD_WIDTH-1:0]     near2_x;
    logic signed [COORD_WIDTH-1:0]     near2_y;
    logic signed [COORD_WIDTH-1:0]     near2_z;
    logic        [sscp_pkg::DIST_W-1:0] squared_distance;
    logic                              distance_saturated;

    modport source (
        output valid, param_s, param_t, near1_x, near1_y, near1_z,
               near2_x, near2_y, near2_z, squared_distance, distance_saturated,
        input  ready
    );
    modport sink (
        input  valid, param_s, param_t, near1_x, near1_y, near1_z,
               near2_x, near2_y, near2_z, squared_distance, distance_saturated,
        output ready
    );
endinterface

// ===== design/sscp_div.sv =====
module sscp_div #(
    parameter int NW = 138,
    parameter int QB = sscp_pkg::PARAM_FRAC_DEF,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [QB:0]          o_quot,
    output logic [SW-1:0]        o_side
);

    logic          r_v    [0:QB];
    logic          r_zf   [0:QB];
    logic          r_of   [0:QB];
    logic [QB-1:0] r_q    [0:QB];
    logic [SW-1:0] r_side [0:QB];
    logic [NW-1:0] r_rem  [0:QB-1];
    logic [NW-1:0] r_den  [0:QB-1];

    // Entry: clamp checks, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_zf[0]   <= i_den[NW-1] || (i_den == '0) || i_num[NW-1] || (i_num == '0);
            r_of[0]   <= i_num >= i_den;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stg
        logic [NW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = {r_rem[k-1][NW-2:0], 1'b0};
        assign w_ge    = w_trial >= r_den[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_zf[k]   <= r_zf[k-1];
                r_of[k]   <= r_of[k-1];
                r_q[k]    <= {r_q[k-1][QB-2:0], w_ge};
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (w_trial - r_den[k-1]) : w_trial;
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_side  = r_side[QB];
    assign o_quot  = r_zf[QB] ? '0 :
                     r_of[QB] ? ((QB+1)'(1) << QB) : {1'b0, r_q[QB]};

endmodule

// ===== design/segment_segment_closest_points_core.sv =====
// Channel   Dir  Handshake     Payload
// i_seg     in   valid/ready   two segments, start and end points, signed coordinates
// o_res     out  valid/ready   s, t, both near points, squared distance, saturation flag
// i_cfg_*   in   write enable  degenerate threshold (squared length), no read-back
//
// One transaction per cycle is accepted and one result per cycle is delivered, unless the output stalls.
// The pipeline has fourteen arithmetic stages plus two restoring dividers that resolve
// one quotient bit per stage.
// Reset is synchronous, active low; it clears the valid bits and the threshold.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module segment_segment_closest_points_core #(
    parameter int COORD_WIDTH     = sscp_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = sscp_pkg::PARAM_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sscp_pkg::THR_W-1:0] i_cfg_wdata,
    sscp_in_if.sink                    i_seg,
    sscp_out_if.source                 o_res
);

    localparam int CW   = COORD_WIDTH;
    localparam int PF   = PARAM_FRAC_BITS;
    localparam int DW   = CW + 1;            // coordinate differences
    localparam int PW   = 2 * DW;            // one coordinate product
    localparam int DOTW = PW + 2;            // dot products a, b, c, e, f
    localparam int WW   = 2 * DOTW;          // products of dot products
    localparam int HL   = (DOTW + 1) / 2;    // low half of a split operand
    localparam int HH   = DOTW - HL;         // high half of a split operand
    localparam int PPW  = 2 * HL + 2;        // one partial product
    localparam int BSW  = HL + PF + 3;       // b * s partial product
    localparam int TW   = DOTW + PF + 2;     // second division operands
    localparam int NPW  = DW + PF + 2;       // d * s along a segment
    localparam int DSTW = sscp_pkg::DIST_W;
    localparam int SQW  = (DOTW > DSTW) ? DOTW : DSTW + 1;

    localparam logic        [PF:0]    ONE = (PF+1)'(1) << PF;
    localparam logic signed [NPW-1:0] RND = NPW'(1) << (PF - 1);

    typedef struct packed {
        logic [2:0][CW-1:0] p1;
        logic [2:0][DW-1:0] d1;
        logic [2:0][CW-1:0] p2;
        logic [2:0][DW-1:0] d2;
    } t_geo;

    typedef struct packed {
        t_geo            geo;
        logic [DOTW-1:0] a;
        logic [DOTW-1:0] b;
        logic [DOTW-1:0] c;
        logic [DOTW-1:0] e;
        logic [DOTW-1:0] f;
        logic            adeg;
        logic            edeg;
    } t_side1;

    typedef struct packed {
        t_geo        geo;
        logic [PF:0] fixv;     // value of the parameter the divider does not produce
        logic        tgt_s;    // divider result is s (else t)
    } t_side2;

    typedef struct packed {
        logic signed [PPW-1:0] ll;
        logic signed [PPW-1:0] lh;
        logic signed [PPW-1:0] hl;
        logic signed [PPW-1:0] hh;
    } t_pp;

    // Split a wide product into four narrow ones
    function automatic t_pp f_pp(input logic signed [DOTW-1:0] x,
                                 input logic signed [DOTW-1:0] y);
        logic signed [HL:0]   xl;
        logic signed [HL:0]   yl;
        logic signed [HH-1:0] xh;
        logic signed [HH-1:0] yh;
        t_pp                  r;
        xl   = $signed({1'b0, x[HL-1:0]});
        yl   = $signed({1'b0, y[HL-1:0]});
        xh   = x[DOTW-1:HL];
        yh   = y[DOTW-1:HL];
        r.ll = PPW'(xl) * PPW'(yl);
        r.lh = PPW'(xl) * PPW'(yh);
        r.hl = PPW'(xh) * PPW'(yl);
        r.hh = PPW'(xh) * PPW'(yh);
        return r;
    endfunction

    function automatic logic signed [WW-1:0] f_cmb(input t_pp p);
        return (WW'($signed(p.hh)) <<< (2 * HL))
             + ((WW'($signed(p.lh)) + WW'($signed(p.hl))) <<< HL)
             + WW'($signed(p.ll));
    endfunction

    // ---------------------------------------------------------------
    // Flow control: every stage advances together when the output
    // register is free or being drained.
    // ---------------------------------------------------------------
    logic w_en;
    logic r_ov;

    assign w_en        = !r_ov || o_res.ready;
    assign i_seg.ready = w_en;

    // Threshold register
    logic [sscp_pkg::THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: direction vectors and start-point offset
    // ---------------------------------------------------------------
    logic signed [CW-1:0] w_p1 [3];
    logic signed [CW-1:0] w_q1 [3];
    logic signed [CW-1:0] w_p2 [3];
    logic signed [CW-1:0] w_q2 [3];

    assign w_p1[0] = i_seg.seg1_start_x;
    assign w_p1[1] = i_seg.seg1_start_y;
    assign w_p1[2] = i_seg.seg1_start_z;
    assign w_q1[0] = i_seg.seg1_end_x;
    assign w_q1[1] = i_seg.seg1_end_y;
    assign w_q1[2] = i_seg.seg1_end_z;
    assign w_p2[0] = i_seg.seg2_start_x;
    assign w_p2[1] = i_seg.seg2_start_y;
    assign w_p2[2] = i_seg.seg2_start_z;
    assign w_q2[0] = i_seg.seg2_end_x;
    assign w_q2[1] = i_seg.seg2_end_y;
    assign w_q2[2] = i_seg.seg2_end_z;

    t_geo                 n1_geo;
    logic signed [DW-1:0] n1_r [3];
    t_geo                 r1_geo;
    logic signed [DW-1:0] r1_r [3];
    logic                 r1_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_geo.p1[i] = w_p1[i];
            n1_geo.p2[i] = w_p2[i];
            n1_geo.d1[i] = DW'(w_q1[i]) - DW'(w_p1[i]);
            n1_geo.d2[i] = DW'(w_q2[i]) - DW'(w_p2[i]);
            n1_r[i]      = DW'(w_p1[i]) - DW'(w_p2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_seg.valid;
        end
        if (w_en) begin
            r1_geo <= n1_geo;
            r1_r   <= n1_r;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: per-axis products for a, e, b, c, f
    // ---------------------------------------------------------------
    logic signed [PW-1:0] n2_prd [5][3];
    logic signed [PW-1:0] r2_prd [5][3];
    t_geo                 r2_geo;
    logic                 r2_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_prd[0][i] = PW'($signed(r1_geo.d1[i])) * PW'($signed(r1_geo.d1[i]));
            n2_prd[1][i] = PW'($signed(r1_geo.d2[i])) * PW'($signed(r1_geo.d2[i]));
            n2_prd[2][i] = PW'($signed(r1_geo.d1[i])) * PW'($signed(r1_geo.d2[i]));
            n2_prd[3][i] = PW'($signed(r1_geo.d1[i])) * PW'(r1_r[i]);
            n2_prd[4][i] = PW'($signed(r1_geo.d2[i])) * PW'(r1_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_prd <= n2_prd;
            r2_geo <= r1_geo;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: dot products
    // ---------------------------------------------------------------
    logic signed [DOTW-1:0] n3_dot [5];
    logic signed [DOTW-1:0] r3_dot [5];
    t_geo                   r3_geo;
    logic                   r3_v;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n3_dot[k] = DOTW'(r2_prd[k][0]) + DOTW'(r2_prd[k][1]) + DOTW'(r2_prd[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
        if (w_en) begin
            r3_dot <= n3_dot;
            r3_geo <= r2_geo;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: degenerate tests, partial products of a*e, b*b, b*f, c*e
    // ---------------------------------------------------------------
    logic signed [DOTW-1:0] w_thr;
    t_side1                 n4_side;
    t_pp                    n4_pp [4];
    t_side1                 r4_side;
    t_pp                    r4_pp [4];
    logic                   r4_v;

    assign w_thr = $signed(DOTW'({1'b0, r_thr}));

    always_comb begin
        n4_side.geo  = r3_geo;
        n4_side.a    = r3_dot[0];
        n4_side.e    = r3_dot[1];
        n4_side.b    = r3_dot[2];
        n4_side.c    = r3_dot[3];
        n4_side.f    = r3_dot[4];
        n4_side.adeg = r3_dot[0] <= w_thr;
        n4_side.edeg = r3_dot[1] <= w_thr;
        n4_pp[0]     = f_pp(r3_dot[0], r3_dot[1]);
        n4_pp[1]     = f_pp(r3_dot[2], r3_dot[2]);
        n4_pp[2]     = f_pp(r3_dot[2], r3_dot[4]);
        n4_pp[3]     = f_pp(r3_dot[3], r3_dot[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
        if (w_en) begin
            r4_side <= n4_side;
            r4_pp   <= n4_pp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: assemble the wide products
    // ---------------------------------------------------------------
    logic signed [WW-1:0] r5_prd [4];
    t_side1               r5_side;
    logic                 r5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r5_prd[k] <= f_cmb(r4_pp[k]);
            end
            r5_side <= r4_side;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: s numerator b*f - c*e, denominator a*e - b*b
    // ---------------------------------------------------------------
    logic signed [WW-1:0] r6_num;
    logic signed [WW-1:0] r6_den;
    t_side1               r6_side;
    logic                 r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
        if (w_en) begin
            r6_num  <= r5_prd[2] - r5_prd[3];
            r6_den  <= r5_prd[0] - r5_prd[1];
            r6_side <= r5_side;
        end
    end

    // First divider: s for the general case, clamped to [0, 1]
    logic                      w_d1_v;
    logic [PF:0]               w_d1_q;
    logic [$bits(t_side1)-1:0] w_d1_side;
    t_side1                    w_s1;

    sscp_div #(
        .NW (WW),
        .QB (PF),
        .SW ($bits(t_side1))
    ) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_side  (r6_side),
        .o_valid (w_d1_v),
        .o_quot  (w_d1_q),
        .o_side  (w_d1_side)
    );

    assign w_s1 = w_d1_side;

    // ---------------------------------------------------------------
    // Stage 7: b * s, split in two narrow products
    // ---------------------------------------------------------------
    logic [PF:0]           w_s0;
    logic signed [HL:0]    w_bl;
    logic signed [HH-1:0]  w_bh;
    logic signed [BSW-1:0] r7_bsl;
    logic signed [BSW-1:0] r7_bsh;
    logic [PF:0]           r7_s0;
    t_side1                r7_side;
    logic                  r7_v;

    assign w_s0 = (w_s1.adeg || w_s1.edeg) ? '0 : w_d1_q;
    assign w_bl = $signed({1'b0, w_s1.b[HL-1:0]});
    assign w_bh = w_s1.b[DOTW-1:HL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= w_d1_v;
        end
        if (w_en) begin
            r7_bsl  <= BSW'(w_bl) * BSW'($signed({1'b0, w_s0}));
            r7_bsh  <= BSW'(w_bh) * BSW'($signed({1'b0, w_s0}));
            r7_s0   <= w_s0;
            r7_side <= w_s1;
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: t numerator b*s + f*2^PF and denominator e*2^PF
    // ---------------------------------------------------------------
    logic signed [TW-1:0] r8_tnum;
    logic signed [TW-1:0] r8_tden;
    logic [PF:0]          r8_s0;
    t_side1               r8_side;
    logic                 r8_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= r7_v;
        end
        if (w_en) begin
            r8_tnum <= (TW'(r7_bsh) <<< HL) + TW'(r7_bsl)
                     + (TW'($signed(r7_side.f)) <<< PF);
            r8_tden <= TW'($signed(r7_side.e)) <<< PF;
            r8_s0   <= r7_s0;
            r8_side <= r7_side;
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: pick the second division. A point segment or a t that
    // leaves [0,1] pins one parameter and recomputes the other.
    // ---------------------------------------------------------------
    logic signed [TW-1:0] w_ta;
    logic signed [TW-1:0] w_te;
    logic signed [TW-1:0] w_tf;
    logic signed [TW-1:0] w_nc;
    logic signed [TW-1:0] w_bc;
    logic signed [TW-1:0] n9_num;
    logic signed [TW-1:0] n9_den;
    t_side2               n9_side;
    logic signed [TW-1:0] r9_num;
    logic signed [TW-1:0] r9_den;
    t_side2               r9_side;
    logic                 r9_v;

    always_comb begin
        w_ta = TW'($signed(r8_side.a));
        w_te = TW'($signed(r8_side.e));
        w_tf = TW'($signed(r8_side.f));
        w_nc = -TW'($signed(r8_side.c));
        w_bc = TW'($signed(r8_side.b)) - TW'($signed(r8_side.c));
        n9_side.geo = r8_side.geo;
        if (r8_side.adeg && r8_side.edeg) begin
            n9_num        = '0;
            n9_den        = w_te;
            n9_side.tgt_s = 1'b0;
            n9_side.fixv  = '0;
        end else if (r8_side.adeg) begin
            n9_num        = w_tf;
            n9_den        = w_te;
            n9_side.tgt_s = 1'b0;
            n9_side.fixv  = '0;
        end else if (r8_side.edeg) begin
            n9_num        = w_nc;
            n9_den        = w_ta;
            n9_side.tgt_s = 1'b1;
            n9_side.fixv  = '0;
        end else if (r8_tnum[TW-1]) begin
            n9_num        = w_nc;
            n9_den        = w_ta;
            n9_side.tgt_s = 1'b1;
            n9_side.fixv  = '0;
        end else if (r8_tnum > r8_tden) begin
            n9_num        = w_bc;
            n9_den        = w_ta;
            n9_side.tgt_s = 1'b1;
            n9_side.fixv  = ONE;
        end else begin
            n9_num        = r8_tnum;
            n9_den        = r8_tden;
            n9_side.tgt_s = 1'b0;
            n9_side.fixv  = r8_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (w_en) begin
            r9_v <= r8_v;
        end
        if (w_en) begin
            r9_num  <= n9_num;
            r9_den  <= n9_den;
            r9_side <= n9_side;
        end
    end

    // Second divider: final s or t
    logic                      w_d2_v;
    logic [PF:0]               w_d2_q;
    logic [$bits(t_side2)-1:0] w_d2_side;
    t_side2                    w_s2;

    sscp_div #(
        .NW (TW),
        .QB (PF),
        .SW ($bits(t_side2))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r9_v),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_side),
        .o_valid (w_d2_v),
        .o_quot  (w_d2_q),
        .o_side  (w_d2_side)
    );

    assign w_s2 = w_d2_side;

    // ---------------------------------------------------------------
    // Stage 10: d * s along each segment
    // ---------------------------------------------------------------
    logic [PF:0]           w_s;
    logic [PF:0]           w_t;
    logic signed [NPW-1:0] r10_m1 [3];
    logic signed [NPW-1:0] r10_m2 [3];
    logic signed [CW-1:0]  r10_p1 [3];
    logic signed [CW-1:0]  r10_p2 [3];
    logic [PF:0]           r10_s;
    logic [PF:0]           r10_t;
    logic                  r10_v;

    assign w_s = w_s2.tgt_s ? w_d2_q : w_s2.fixv;
    assign w_t = w_s2.tgt_s ? w_s2.fixv : w_d2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (w_en) begin
            r10_v <= w_d2_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r10_m1[i] <= NPW'($signed(w_s2.geo.d1[i])) * NPW'($signed({1'b0, w_s}));
                r10_m2[i] <= NPW'($signed(w_s2.geo.d2[i])) * NPW'($signed({1'b0, w_t}));
                r10_p1[i] <= w_s2.geo.p1[i];
                r10_p2[i] <= w_s2.geo.p2[i];
            end
            r10_s <= w_s;
            r10_t <= w_t;
        end
    end

    // ---------------------------------------------------------------
    // Stage 11: near points, rounded to nearest with halves up
    // ---------------------------------------------------------------
    logic signed [CW-1:0] r11_c1 [3];
    logic signed [CW-1:0] r11_c2 [3];
    logic [PF:0]          r11_s;
    logic [PF:0]          r11_t;
    logic                 r11_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (w_en) begin
            r11_v <= r10_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r11_c1[i] <= r10_p1[i] + CW'((r10_m1[i] + RND) >>> PF);
                r11_c2[i] <= r10_p2[i] + CW'((r10_m2[i] + RND) >>> PF);
            end
            r11_s <= r10_s;
            r11_t <= r10_t;
        end
    end

    // ---------------------------------------------------------------
    // Stage 12: separation vector
    // ---------------------------------------------------------------
    logic signed [DW-1:0] r12_dd [3];
    logic signed [CW-1:0] r12_c1 [3];
    logic signed [CW-1:0] r12_c2 [3];
    logic [PF:0]          r12_s;
    logic [PF:0]          r12_t;
    logic                 r12_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (w_en) begin
            r12_v <= r11_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r12_dd[i] <= DW'(r11_c1[i]) - DW'(r11_c2[i]);
            end
            r12_c1 <= r11_c1;
            r12_c2 <= r11_c2;
            r12_s  <= r11_s;
            r12_t  <= r11_t;
        end
    end

    // ---------------------------------------------------------------
    // Stage 13: squares of the separation
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r13_sq [3];
    logic signed [CW-1:0] r13_c1 [3];
    logic signed [CW-1:0] r13_c2 [3];
    logic [PF:0]          r13_s;
    logic [PF:0]          r13_t;
    logic                 r13_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0;
        end else if (w_en) begin
            r13_v <= r12_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r13_sq[i] <= PW'(r12_dd[i]) * PW'(r12_dd[i]);
            end
            r13_c1 <= r12_c1;
            r13_c2 <= r12_c2;
            r13_s  <= r12_s;
            r13_t  <= r12_t;
        end
    end

    // ---------------------------------------------------------------
    // Output register: sum, saturate, present
    // ---------------------------------------------------------------
    logic signed [DOTW-1:0] w_sum;
    logic [SQW-1:0]         w_ext;
    logic                   w_sat;
    logic [PF:0]            r_o_s;
    logic [PF:0]            r_o_t;
    logic signed [CW-1:0]   r_o_c1 [3];
    logic signed [CW-1:0]   r_o_c2 [3];
    logic [DSTW-1:0]        r_o_dist;
    logic                   r_o_sat;

    assign w_sum = DOTW'(r13_sq[0]) + DOTW'(r13_sq[1]) + DOTW'(r13_sq[2]);
    assign w_ext = SQW'(w_sum);
    assign w_sat = |w_ext[SQW-1:DSTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r13_v;
        end
        if (w_en) begin
            r_o_s    <= r13_s;
            r_o_t    <= r13_t;
            r_o_c1   <= r13_c1;
            r_o_c2   <= r13_c2;
            r_o_dist <= w_sat ? '1 : w_ext[DSTW-1:0];
            r_o_sat  <= w_sat;
        end
    end

    assign o_res.valid              = r_ov;
    assign o_res.param_s            = r_o_s;
    assign o_res.param_t            = r_o_t;
    assign o_res.near1_x            = r_o_c1[0];
    assign o_res.near1_y            = r_o_c1[1];
    assign o_res.near1_z            = r_o_c1[2];
    assign o_res.near2_x            = r_o_c2[0];
    assign o_res.near2_y            = r_o_c2[1];
    assign o_res.near2_z            = r_o_c2[2];
    assign o_res.squared_distance   = r_o_dist;
    assign o_res.distance_saturated = r_o_sat;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_s <= ONE) && (r_o_t <= ONE))
        else $error("s or t beyond 1.0");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_sat |-> (&r_o_dist))
        else $error("saturated distance not all ones");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r1_v) && $stable(r9_v) && $stable(r13_v))
        else $error("pipeline moved during a stall");

endmodule

// ===== sim/segment_segment_closest_points_core_tb.sv =====
module segment_segment_closest_points_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PFB      = sscp_pkg::PARAM_FRAC_DEF;
    localparam int CW       = sscp_pkg::COORD_WIDTH_DEF;
    localparam int N_RANDOM = 1850;
    // pipeline depth plus margin, used as the drain wait
    localparam int DRAIN    = 2 * PFB + 16 + 20;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [191:0]   t_wide;
    typedef t_coord                t_pair [12];

    typedef struct {
        logic [PFB:0]                s;
        logic [PFB:0]                t;
        t_coord                      near [6];
        logic [sscp_pkg::DIST_W-1:0] sq_dist;
        logic                        sat;
    } t_closest;

    typedef struct {
        t_pair    c;
        bit       typed;
        t_closest want;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [sscp_pkg::THR_W-1:0] cfg_wdata = '0;
    logic [sscp_pkg::THR_W-1:0] threshold = '0;

    sscp_in_if  seg_if ();
    sscp_out_if res_if ();

    segment_segment_closest_points_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_seg       (seg_if),
        .o_res       (res_if)
    );

    always #4 i_clk = ~i_clk;

    t_closest pending_closest [$];
    int       err_cnt = 0;
    int       n_checked = 0;
    int       n_sat = 0;
    bit       steady = 1'b0;   // when set, both sides run without gaps

    // Floor quotient clamped to [0, 1.0] in Q1.PFB.
    function automatic logic [PFB:0] clamp_quot(t_wide num, t_wide den);
        logic [PFB:0] q;
        q = '0;
        if (den <= 0 || num <= 0) return '0;
        if (num >= den) return (PFB+1)'(1) << PFB;
        for (int i = 0; i < PFB; i++) begin
            num = num <<< 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_closest closest_of(t_pair c, logic [31:0] thr);
        t_wide    p1 [3], d1 [3], p2 [3], d2 [3], r [3], dd [3];
        t_wide    a, e, f, cc, b, den, tnum, tden, wthr, sw, tw, w, dw;
        t_closest o;
        a = 0; e = 0; f = 0; cc = 0; b = 0; dw = 0;
        for (int i = 0; i < 3; i++) begin
            p1[i] = t_wide'(c[i]);
            d1[i] = t_wide'(c[3+i]) - p1[i];
            p2[i] = t_wide'(c[6+i]);
            d2[i] = t_wide'(c[9+i]) - p2[i];
            r[i]  = p1[i] - p2[i];
            a  = a + d1[i] * d1[i];
            e  = e + d2[i] * d2[i];
            f  = f + d2[i] * r[i];
            cc = cc + d1[i] * r[i];
            b  = b + d1[i] * d2[i];
        end
        wthr = t_wide'({1'b0, thr});
        if (a <= wthr && e <= wthr) begin
            o.s = '0;
            o.t = '0;
        end else if (a <= wthr) begin
            o.s = '0;
            o.t = clamp_quot(f, e);
        end else if (e <= wthr) begin
            o.t = '0;
            o.s = clamp_quot(-cc, a);
        end else begin
            den = a * e - b * b;
            o.s = (den == 0) ? '0 : clamp_quot(b * f - cc * e, den);
            // t numerator uses the quantized s, so scale f and e to match
            sw   = t_wide'({1'b0, o.s});
            tnum = b * sw + (f <<< PFB);
            tden = e <<< PFB;
            if (tnum < 0) begin
                o.t = '0;
                o.s = clamp_quot(-cc, a);
            end else if (tnum > tden) begin
                o.t = (PFB+1)'(1) << PFB;
                o.s = clamp_quot(b - cc, a);
            end else begin
                o.t = clamp_quot(tnum, tden);
            end
        end
        sw = t_wide'({1'b0, o.s});
        tw = t_wide'({1'b0, o.t});
        for (int i = 0; i < 3; i++) begin
            // round half up, then drop the fraction bits
            w = (d1[i] * sw + (t_wide'(1) <<< (PFB-1))) >>> PFB;
            w = p1[i] + w;
            o.near[i] = t_coord'(w);
            dd[i] = w;
            w = (d2[i] * tw + (t_wide'(1) <<< (PFB-1))) >>> PFB;
            w = p2[i] + w;
            o.near[3+i] = t_coord'(w);
            dd[i] = dd[i] - w;
            dw = dw + dd[i] * dd[i];
        end
        o.sat     = (dw[191:64] != 0);
        o.sq_dist = o.sat ? '1 : dw[63:0];
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        if (steady) return 0;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 2097152)) - 1048576);
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(CW-1){1'b0}}};
                    1: return {1'b0, {(CW-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_pair rnd_pair();
        t_pair c;
        int    kind, mode, k;
        kind = $urandom_range(0, 9);
        mode = (kind <= 2) ? 0 : (kind == 9) ? 2 : 1;
        for (int i = 0; i < 12; i++) c[i] = rnd_coord(mode);
        case (kind)
            6: for (int i = 0; i < 3; i++)       // first segment shrunk to a point
                   c[3+i] = c[i] + t_coord'($signed($urandom_range(0, 4)) - 2);
            7: for (int i = 0; i < 3; i++)       // second segment shrunk to a point
                   c[9+i] = c[6+i] + t_coord'($signed($urandom_range(0, 4)) - 2);
            8: begin                             // second segment parallel to the first
                k = $signed($urandom_range(0, 6)) - 3;
                for (int i = 0; i < 3; i++)
                    c[9+i] = c[6+i] + t_coord'(k * (c[3+i] - c[i]));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_threshold(logic [31:0] v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        threshold = v;
    endtask

    // Hold valid until the block takes the transaction; record the expectation.
    task automatic send_pair(t_pair c, bit typed, t_closest want);
        int g;
        g = gap_len();
        if (g > 0) begin
            seg_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        seg_if.valid        <= 1'b1;
        seg_if.seg1_start_x <= c[0];
        seg_if.seg1_start_y <= c[1];
        seg_if.seg1_start_z <= c[2];
        seg_if.seg1_end_x   <= c[3];
        seg_if.seg1_end_y   <= c[4];
        seg_if.seg1_end_z   <= c[5];
        seg_if.seg2_start_x <= c[6];
        seg_if.seg2_start_y <= c[7];
        seg_if.seg2_start_z <= c[8];
        seg_if.seg2_end_x   <= c[9];
        seg_if.seg2_end_y   <= c[10];
        seg_if.seg2_end_z   <= c[11];
        do @(posedge i_clk); while (!seg_if.ready);
        pending_closest.push_back(typed ? want : closest_of(c, threshold));
        @(negedge i_clk);
    endtask

    // Drop valid and let the pipeline drain before touching the register.
    task automatic drain_all();
        seg_if.valid <= 1'b0;
        wait (pending_closest.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Random receiver stall, changed at the falling edge only.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            stall_left <= gap_len();
            res_if.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endtask

    // Compare each delivered transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_closest w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_closest.size() == 0) begin
                $error("result with no pending expectation");
                err_cnt++;
            end else begin
                w = pending_closest.pop_front();
                check_field("param_s", w.s, res_if.param_s);
                check_field("param_t", w.t, res_if.param_t);
                check_field("near1_x", w.near[0], res_if.near1_x);
                check_field("near1_y", w.near[1], res_if.near1_y);
                check_field("near1_z", w.near[2], res_if.near1_z);
                check_field("near2_x", w.near[3], res_if.near2_x);
                check_field("near2_y", w.near[4], res_if.near2_y);
                check_field("near2_z", w.near[5], res_if.near2_z);
                check_field("squared_distance", w.sq_dist, res_if.squared_distance);
                check_field("distance_saturated", w.sat, res_if.distance_saturated);
                n_checked++;
                if (w.sat) n_sat++;
            end
        end
    end

    function automatic t_row mk_row(t_pair c);
        t_row r;
        r.c = c;
        r.typed = 1'b0;
        r.want = '{s: '0, t: '0, near: '{default: '0}, sq_dist: '0, sat: 1'b0};
        return r;
    endfunction

    localparam t_coord CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord U1   = t_coord'(1 << 16);

    t_row directed [$];

    initial begin
        t_row     r;
        t_closest none;
        none = '{s: '0, t: '0, near: '{default: '0}, sq_dist: '0, sat: 1'b0};

        seg_if.valid <= 1'b0;
        {seg_if.seg1_start_x, seg_if.seg1_start_y, seg_if.seg1_start_z,
         seg_if.seg1_end_x, seg_if.seg1_end_y, seg_if.seg1_end_z,
         seg_if.seg2_start_x, seg_if.seg2_start_y, seg_if.seg2_start_z,
         seg_if.seg2_end_x, seg_if.seg2_end_y, seg_if.seg2_end_z} <= '0;

        // all zero: both segments are points at the origin
        r = mk_row('{default: '0});
        r.typed = 1'b1;
        directed.push_back(r);
        // unit segments crossing at the origin meet at their midpoints
        r = mk_row('{-U1, '0, '0, U1, '0, '0, '0, -U1, '0, '0, U1, '0});
        r.typed = 1'b1;
        r.want = none;
        r.want.s = (PFB+1)'(1) << (PFB-1);
        r.want.t = (PFB+1)'(1) << (PFB-1);
        directed.push_back(r);
        // two points at opposite corners: distance saturates
        r = mk_row('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                     CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
        r.typed = 1'b1;
        r.want = none;
        r.want.near    = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX};
        r.want.sq_dist = '1;
        r.want.sat     = 1'b1;
        directed.push_back(r);
        // full-range diagonals, crossing and reversed
        directed.push_back(mk_row('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                    CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}));
        directed.push_back(mk_row('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
                                    CMIN, CMIN, CMAX, CMAX, CMAX, CMIN}));
        // identical segments (parallel)
        directed.push_back(mk_row('{'0, '0, '0, U1, U1, '0, '0, '0, '0, U1, U1, '0}));
        // parallel offset, and anti-parallel
        directed.push_back(mk_row('{'0, '0, '0, U1, '0, '0, '0, U1, '0, 3*U1, U1, '0}));
        directed.push_back(mk_row('{'0, '0, '0, U1, '0, '0, 2*U1, U1, '0, -U1, U1, '0}));
        // t clamps below zero and above one
        directed.push_back(mk_row('{'0, '0, '0, U1, '0, '0, 3*U1, U1, U1, 5*U1, 2*U1, U1}));
        directed.push_back(mk_row('{'0, '0, '0, U1, '0, '0, -3*U1, -U1, U1, -U1, '0, U1}));
        // first segment a point, second segment a point
        directed.push_back(mk_row('{U1, U1, U1, U1, U1, U1, '0, '0, '0, 4*U1, '0, '0}));
        directed.push_back(mk_row('{'0, '0, '0, 4*U1, '0, '0, U1, U1, U1, U1, U1, U1}));
        // length one LSB segments, near the threshold edge
        directed.push_back(mk_row('{'0, '0, '0, 1, '0, '0, 5, 5, 5, 5, 6, 5}));
        directed.push_back(mk_row('{'1, '1, '1, '0, '0, '0, 7, '1, 3, 7, '0, 3}));
        // odd fractions for near-point rounding
        directed.push_back(mk_row('{3, -7, 11, 100003, 70001, -9, -5, 40000, 2,
                                    60013, -1, 33333}));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at the reset threshold of zero
        foreach (directed[i]) send_pair(directed[i].c, directed[i].typed, directed[i].want);
        drain_all();

        // random phases across thresholds, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_threshold('1);
                1: write_threshold(32'd8);
                2: write_threshold($urandom);
                3: write_threshold(32'd1);
                default: write_threshold('0);
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (n % 120 == 0) steady = ($urandom_range(0, 3) == 0);
                send_pair(rnd_pair(), 1'b0, none);
            end
            steady = 1'b0;
            drain_all();
        end

        $display("Checked %0d results over directed rows and five threshold settings,",
                 n_checked);
        $display("with %0d saturated distances and random stalls on both channels.", n_sat);
        if (err_cnt == 0 && pending_closest.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
